/* sv/pps_pkg.sv */
package pps_pkg;

  localparam int MAX_WP  = 1024;
  localparam int WP_AW   = $clog2(MAX_WP);
  localparam int CNT_W   = WP_AW + 1;
  localparam int PADDR_W = 4;

  // register map, word index = paddr[3:2]
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_GAIN   = 2'd1;
  localparam logic [1:0] REG_DRIVE  = 2'd2;
  localparam logic [1:0] REG_COUNT  = 2'd3;

  localparam logic [30:0] RADIUS_RST = 31'd65536;
  localparam logic [15:0] GAIN_RST   = 16'd2048;
  localparam logic        DRIVE_RST  = 1'b1;
  localparam logic [CNT_W-1:0] COUNT_RST = '0;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_POSE  = 1'b1;

  localparam logic [30:0] STEER_MAX     = 31'h7FFF_FFFF;
  localparam logic [30:0] BAND_FAST_MAX = 31'd11438;
  localparam logic [30:0] BAND_MID_MAX  = 31'd22876;

  localparam logic [1:0] SPEED_STOP = 2'd0;
  localparam logic [1:0] SPEED_SLOW = 2'd1;
  localparam logic [1:0] SPEED_MID  = 2'd2;
  localparam logic [1:0] SPEED_FAST = 2'd3;

  // divider: numerator gain*|y| (48 bits) scaled by 2^21
  localparam int NUM_W      = 48;
  localparam int FRAC_SHIFT = 21;
  localparam int DIV_W      = NUM_W + FRAC_SHIFT;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [15:0] quat_t;
  typedef logic [WP_AW-1:0]   wp_addr_t;

endpackage

/* sv/pps_item_if.sv */
interface pps_item_if;
  logic                valid;
  logic                ready;
  logic                func;
  pps_pkg::wp_addr_t   wp_index;
  pps_pkg::q16_t       pos_x;
  pps_pkg::q16_t       pos_y;
  pps_pkg::q16_t       trans_x;
  pps_pkg::q16_t       trans_y;
  pps_pkg::q16_t       trans_z;
  pps_pkg::quat_t      quat_w;
  pps_pkg::quat_t      quat_x;
  pps_pkg::quat_t      quat_y;
  pps_pkg::quat_t      quat_z;

  modport source(output valid, func, wp_index, pos_x, pos_y, trans_x, trans_y, trans_z,
                 quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, func, wp_index, pos_x, pos_y, trans_x, trans_y, trans_z,
               quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

/* sv/pps_result_if.sv */
interface pps_result_if;
  logic              valid;
  logic              ready;
  pps_pkg::q16_t     steer_angle;
  logic [1:0]        speed_code;
  pps_pkg::wp_addr_t selected_index;
  logic              point_found;
  logic              range_fault;

  modport source(output valid, steer_angle, speed_code, selected_index, point_found,
                 range_fault, input ready);
  modport sink(input valid, steer_angle, speed_code, selected_index, point_found,
               range_fault, output ready);
endinterface

/* sv/pps_div.sv */
module pps_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pps_pkg::NUM_W-1:0]   num,
  input  logic [63:0]                 den,
  output logic                        done,
  output logic [30:0]                 quo
);

  localparam int CW = $clog2(pps_pkg::DIV_W);

  logic [pps_pkg::DIV_W-1:0] sh;
  logic [63:0]  rem;
  logic [30:0]  q;
  logic         ovf;
  logic         busy;
  logic [CW-1:0] cnt;
  logic [64:0]  rs;
  logic [64:0]  diff;
  logic         ge;

  assign rs   = {rem, sh[pps_pkg::DIV_W-1]};
  assign ge   = rs >= {1'b0, den};
  assign diff = rs - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(pps_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle; bits beyond 31 only set overflow
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= {num, {pps_pkg::FRAC_SHIFT{1'b0}}};
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      sh  <= {sh[pps_pkg::DIV_W-2:0], 1'b0};
      rem <= ge ? diff[63:0] : rs[63:0];
      q   <= {q[29:0], ge};
      ovf <= ovf | q[30];
    end
  end

  assign quo = ovf ? pps_pkg::STEER_MAX : q;

endmodule

/* sv/pure_pursuit_steering.sv */
// channel   port     dir  word
// item      item     in   func, wp_index, pos_x/y, trans_x/y/z, quat_w/x/y/z
// result    result   out  steer_angle, speed_code, selected_index, flags
// config    apb      in   lookahead_radius, steer_gain, drive_enable, waypoint_count
//
// A waypoint write is taken while the block is idle. A pose update holds item.ready low
// from acceptance until its result is loaded: a scan of n table entries, with
// n = min(waypoint_count, 1024), at one table read per cycle, twelve steps on the shared
// pair of multipliers, then the bit-serial divider (skipped on a zero distance); a
// waiting result stalls it further.
// Reset clears the tracked index and the registers; the waypoint table is not cleared.
module pure_pursuit_steering (
  input  logic                          clk,
  input  logic                          rst,
  pps_item_if.sink                      item,
  pps_result_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pps_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_R2    = 4'd1;
  localparam logic [3:0] S_R2W   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_FETCH = 4'd4;
  localparam logic [3:0] S_CALC  = 4'd5;
  localparam logic [3:0] S_DST   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam int CW = pps_pkg::CNT_W;

  logic [3:0] state;
  logic [3:0] k;

  // configuration
  logic [30:0]   radius;
  logic [15:0]   gain;
  logic          drive;
  logic [CW-1:0] wp_count;

  // pose
  pps_pkg::q16_t  px, py, tx, ty, tz;
  pps_pkg::quat_t qw, qx, qy, qz;

  // table
  logic signed [31:0] mem_x [pps_pkg::MAX_WP];
  logic signed [31:0] mem_y [pps_pkg::MAX_WP];
  logic               rd_en;
  pps_pkg::wp_addr_t  raddr;
  logic signed [31:0] rdx, rdy;

  // scan
  logic [CW-1:0]     sc_i, sc_n;
  logic              v1, v2;
  pps_pkg::wp_addr_t idx1, idx2;
  logic [61:0]       r2;
  logic [62:0]       best;
  logic [62:0]       dsum;
  logic              found;
  pps_pkg::wp_addr_t tracked;
  logic signed [32:0] dxs, dys;
  logic [32:0]        dx, dy;
  logic               ok1;

  // shared multiplier pair
  logic signed [32:0] ma0, mb0, ma1, mb1;
  logic signed [65:0] p0, p1;

  // transform
  logic signed [19:0] r00, r01, r10, r11, r20, r21;
  logic signed [33:0] s_add, s_sub;
  pps_pkg::q16_t      cx, cy, cz;
  logic [31:0]        ax, ay, az;
  logic signed [55:0] acc, shv, car_sum;
  pps_pkg::q16_t      car_t, car_val;
  logic [63:0]        sq_sum, d2;
  logic [pps_pkg::NUM_W-1:0] numer;
  logic               fault;

  // divider
  logic        div_start, div_done;
  logic [30:0] div_quo;

  logic        out_load;
  logic [30:0] steer_mag;
  logic [31:0] steer_pos;
  logic [1:0]  code;

  function automatic logic signed [19:0] rot16(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = v + 34'sd2048;
    return 20'(t >>> 12);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // ---------------- configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= pps_pkg::RADIUS_RST;
      gain     <= pps_pkg::GAIN_RST;
      drive    <= pps_pkg::DRIVE_RST;
      wp_count <= pps_pkg::COUNT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        pps_pkg::REG_RADIUS: radius   <= pwdata[30:0];
        pps_pkg::REG_GAIN:   gain     <= pwdata[15:0];
        pps_pkg::REG_DRIVE:  drive    <= pwdata[0];
        pps_pkg::REG_COUNT:  wp_count <= pwdata[CW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pps_pkg::REG_RADIUS: prdata = {1'b0, radius};
      pps_pkg::REG_GAIN:   prdata = {16'd0, gain};
      pps_pkg::REG_DRIVE:  prdata = {31'd0, drive};
      pps_pkg::REG_COUNT:  prdata = {(32-CW)'(0), wp_count};
    endcase
  end

  // ---------------- table
  assign item.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (item.valid && item.ready && item.func == pps_pkg::FUNC_WRITE) begin
      mem_x[item.wp_index] <= item.pos_x;
      mem_y[item.wp_index] <= item.pos_y;
    end
    if (rd_en) begin
      rdx <= mem_x[raddr];
      rdy <= mem_y[raddr];
    end
  end

  always_comb begin
    rd_en = 1'b0;
    raddr = tracked;
    if (state == S_SCAN && sc_i < sc_n) begin
      rd_en = 1'b1;
      raddr = sc_i[pps_pkg::WP_AW-1:0];
    end else if (state == S_FETCH) begin
      rd_en = 1'b1;
    end
  end

  // ---------------- scan datapath
  assign dxs  = 33'(rdx) - 33'(px);
  assign dys  = 33'(rdy) - 33'(py);
  assign dx   = dxs[32] ? 33'(-dxs) : 33'(dxs);
  assign dy   = dys[32] ? 33'(-dys) : 33'(dys);
  assign ok1  = (dx < {2'b0, radius}) && (dy < {2'b0, radius});
  assign dsum = {1'b0, p0[61:0]} + {1'b0, p1[61:0]};

  // ---------------- transform datapath
  assign s_add = p0[33:0] + p1[33:0];
  assign s_sub = p0[33:0] - p1[33:0];
  assign acc   = p0[55:0] + p1[55:0] + 56'sd32768;
  assign shv   = acc >>> 16;
  assign car_t = (k == 4'd6) ? tx : ((k == 4'd7) ? ty : tz);
  assign car_sum = shv + 56'(car_t);
  always_comb begin
    if (car_sum > 56'sd2147483647)       car_val = 32'sh7FFF_FFFF;
    else if (car_sum < -56'sd2147483648) car_val = 32'sh8000_0000;
    else                                 car_val = car_sum[31:0];
  end
  assign ax = mag32(cx);
  assign ay = mag32(cy);
  assign az = mag32(cz);
  assign sq_sum = p0[63:0] + p1[63:0];

  always_comb begin
    ma0 = '0;
    mb0 = '0;
    ma1 = '0;
    mb1 = '0;
    if (state == S_R2) begin
      ma0 = 33'({2'b0, radius});
      mb0 = 33'({2'b0, radius});
    end else if (state == S_SCAN) begin
      ma0 = 33'({1'b0, dx[31:0]});
      mb0 = 33'({1'b0, dx[31:0]});
      ma1 = 33'({1'b0, dy[31:0]});
      mb1 = 33'({1'b0, dy[31:0]});
    end else if (state == S_CALC) begin
      case (k)
        4'd0: begin ma0 = 33'(qw); mb0 = 33'(qw); ma1 = 33'(qx); mb1 = 33'(qx); end
        4'd1: begin ma0 = 33'(qx); mb0 = 33'(qy); ma1 = 33'(qw); mb1 = 33'(qz); end
        4'd2: begin ma0 = 33'(qw); mb0 = 33'(qw); ma1 = 33'(qy); mb1 = 33'(qy); end
        4'd3: begin ma0 = 33'(qx); mb0 = 33'(qz); ma1 = 33'(qw); mb1 = 33'(qy); end
        4'd4: begin ma0 = 33'(qy); mb0 = 33'(qz); ma1 = 33'(qw); mb1 = 33'(qx); end
        4'd5: begin ma0 = 33'(r00); mb0 = 33'(rdx); ma1 = 33'(r01); mb1 = 33'(rdy); end
        4'd6: begin ma0 = 33'(r10); mb0 = 33'(rdx); ma1 = 33'(r11); mb1 = 33'(rdy); end
        4'd7: begin ma0 = 33'(r20); mb0 = 33'(rdx); ma1 = 33'(r21); mb1 = 33'(rdy); end
        4'd9: begin
          ma0 = 33'({1'b0, ax}); mb0 = 33'({1'b0, ax});
          ma1 = 33'({1'b0, ay}); mb1 = 33'({1'b0, ay});
        end
        4'd10: begin
          ma0 = 33'({1'b0, az});    mb0 = 33'({1'b0, az});
          ma1 = 33'({17'd0, gain}); mb1 = 33'({1'b0, ay});
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p0 <= ma0 * mb0;
    p1 <= ma1 * mb1;
  end

  // ---------------- sequencer
  assign div_start = (state == S_DST) && (d2 != 64'd0);
  assign out_load  = (state == S_OUT) && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      k       <= '0;
      sc_i    <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      tracked <= '0;
      found   <= 1'b0;
      fault   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item.valid && item.func == pps_pkg::FUNC_POSE) begin
            state <= S_R2;
          end
        end
        S_R2: state <= S_R2W;
        S_R2W: begin
          sc_i  <= '0;
          found <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          v1   <= rd_en;
          idx1 <= sc_i[pps_pkg::WP_AW-1:0];
          v2   <= v1 && ok1;
          idx2 <= idx1;
          if (rd_en) sc_i <= sc_i + 1'b1;
          if (v2 && dsum < {1'b0, r2} && dsum > best) begin
            tracked <= idx2;
            found   <= 1'b1;
          end
          if (!rd_en && !v1 && !v2) state <= S_FETCH;
        end
        S_FETCH: begin
          k     <= '0;
          state <= S_CALC;
        end
        S_CALC: begin
          k <= k + 1'b1;
          if (k == 4'd11) state <= S_DST;
        end
        S_DST: begin
          fault <= (d2 == 64'd0);
          state <= (d2 == 64'd0) ? S_OUT : S_DIV;
        end
        S_DIV: if (div_done) state <= S_OUT;
        S_OUT: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      px <= item.pos_x;
      py <= item.pos_y;
      tx <= item.trans_x;
      ty <= item.trans_y;
      tz <= item.trans_z;
      qw <= item.quat_w;
      qx <= item.quat_x;
      qy <= item.quat_y;
      qz <= item.quat_z;
      sc_n <= (wp_count > CW'(pps_pkg::MAX_WP)) ? CW'(pps_pkg::MAX_WP) : wp_count;
    end
    if (state == S_R2W) begin
      r2   <= p0[61:0];
      best <= '0;
    end
    if (state == S_SCAN && v2 && dsum < {1'b0, r2} && dsum > best) begin
      best <= dsum;
    end
    if (state == S_CALC) begin
      case (k)
        4'd1: r00 <= rot16((s_add <<< 1) - 34'sd268435456);
        4'd2: begin
          r01 <= rot16(s_sub <<< 1);
          r10 <= rot16(s_add <<< 1);
        end
        4'd3: r11 <= rot16((s_add <<< 1) - 34'sd268435456);
        4'd4: r20 <= rot16(s_sub <<< 1);
        4'd5: r21 <= rot16(s_add <<< 1);
        4'd6: cx <= car_val;
        4'd7: cy <= car_val;
        4'd8: cz <= car_val;
        4'd10: d2 <= sq_sum;
        4'd11: begin
          d2    <= d2 + p0[63:0];
          numer <= p1[pps_pkg::NUM_W-1:0];
        end
        default: ;
      endcase
    end
  end

  pps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (numer),
    .den   (d2),
    .done  (div_done),
    .quo   (div_quo)
  );

  // ---------------- result word
  assign steer_mag = fault ? pps_pkg::STEER_MAX : div_quo;
  assign steer_pos = {1'b0, steer_mag};

  always_comb begin
    if (!drive)
      code = pps_pkg::SPEED_STOP;
    else if (steer_mag != 31'd0 && steer_mag <= pps_pkg::BAND_FAST_MAX)
      code = pps_pkg::SPEED_FAST;
    else if (steer_mag > pps_pkg::BAND_FAST_MAX && steer_mag <= pps_pkg::BAND_MID_MAX)
      code = pps_pkg::SPEED_MID;
    else
      code = pps_pkg::SPEED_SLOW;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.steer_angle    <= (!fault && cy[31]) ? -steer_pos : steer_pos;
      result.speed_code     <= code;
      result.selected_index <= tracked;
      result.point_found    <= found;
      result.range_fault    <= fault;
    end
  end

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (sc_i <= sc_n))
    else $error("scan counter ran past the waypoint count");

  a_found_inside: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH && found) |-> (best != 63'd0 && best < {1'b0, r2}))
    else $error("selected waypoint not strictly inside lookahead");

  a_found_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH && found) |-> ({1'b0, tracked} < sc_n))
    else $error("selected index beyond scanned range");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (d2 != 64'd0))
    else $error("divider started with zero divisor");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide state");
`endif

endmodule
